// ===== design/uvw_pkg.sv =====
// ============================================================================
// uvw_pkg
// Shared widths and types for the UV to world position pipeline.
// ============================================================================
package uvw_pkg;

    // UV component and difference widths.
    localparam int UV_W      = 16;
    localparam int UVD_W     = UV_W + 1;
    localparam int PROD_W    = 2 * UVD_W;
    localparam int CROSS_W   = PROD_W + 1;

    // World coordinate widths.
    localparam int CRD_W     = 16;
    localparam int WD_W      = CRD_W + 1;
    localparam int WPROD_W   = WD_W + CROSS_W;
    localparam int NUM_W     = WPROD_W + 1;

    // Divider widths: dividend is 2|num| + |sn|, divisor is 2|sn|.
    localparam int D_W       = CROSS_W + 1;
    localparam int RW        = NUM_W + 2;
    localparam int QUOT_BITS = CRD_W + 1;
    localparam int RES_W     = QUOT_BITS + 3;

    // Start to done latency in cycles.
    localparam int LATENCY   = 6 + QUOT_BITS + 1 + 1;

    // Sideband that travels with each axis through the divider.
    typedef struct packed {
        logic                    neg;
        logic                    degen;
        logic signed [CRD_W-1:0] wa;
    } side_t;

endpackage

// ===== design/uv_to_world_position.sv =====
// ============================================================================
// uv_to_world_position
// Maps a lightmap texel UV point to a world position on its 3D triangle.
// ============================================================================
// A request is taken on every cycle that start is high; busy is always low.
// Each request gives exactly one result, shown for one cycle with done high.
// The request passes six stages of cross products and numerators, then the
// 17-bit restoring divider (one quotient bit per stage, plus an overflow
// stage) and a final result register. Results cannot be held off, so
// the receiver must take each one in the cycle done is high.
module uv_to_world_position
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        uv_point,
    input  logic [31:0]        uv_vertex_a,
    input  logic [31:0]        uv_vertex_b,
    input  logic [31:0]        uv_vertex_c,
    input  logic [47:0]        world_vertex_a,
    input  logic [47:0]        world_vertex_b,
    input  logic [47:0]        world_vertex_c,
    output logic               done,
    output logic signed [15:0] world_x,
    output logic signed [15:0] world_y,
    output logic signed [15:0] world_z,
    output logic               degenerate
);

    logic                                front_valid;
    logic [uvw_pkg::RW-1:0]              n_w    [3];
    logic [uvw_pkg::D_W-1:0]             d_w    [3];
    uvw_pkg::side_t                      side_w [3];
    logic                                div_valid [3];
    logic [uvw_pkg::QUOT_BITS-1:0]       q_w    [3];
    logic                                ovf_w  [3];
    uvw_pkg::side_t                      sdo_w  [3];

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Cross products and divider operands.
    uvw_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start),
        .uv_point       (uv_point),
        .uv_vertex_a    (uv_vertex_a),
        .uv_vertex_b    (uv_vertex_b),
        .uv_vertex_c    (uv_vertex_c),
        .world_vertex_a (world_vertex_a),
        .world_vertex_b (world_vertex_b),
        .world_vertex_c (world_vertex_c),
        .out_valid      (front_valid),
        .n_out          (n_w),
        .d_out          (d_w),
        .side_out       (side_w)
    );

    // One divider per axis.
    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        uvw_div u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (front_valid),
            .n_in      (n_w[k]),
            .d_in      (d_w[k]),
            .side_in   (side_w[k]),
            .out_valid (div_valid[k]),
            .q_out     (q_w[k]),
            .ovf_out   (ovf_w[k]),
            .side_out  (sdo_w[k])
        );
    end

    // Sign, offset and saturation.
    uvw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid[0] & div_valid[1] & div_valid[2]),
        .q_in       (q_w),
        .ovf_in     (ovf_w),
        .side_in    (sdo_w),
        .done       (done),
        .world_x    (world_x),
        .world_y    (world_y),
        .world_z    (world_z),
        .degenerate (degenerate)
    );

endmodule

// ===== design/uvw_front.sv =====
// ============================================================================
// uvw_front
// Cross products, numerators and sign folding ahead of the divider.
// ============================================================================
module uvw_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [31:0]                   uv_point,
    input  logic [31:0]                   uv_vertex_a,
    input  logic [31:0]                   uv_vertex_b,
    input  logic [31:0]                   uv_vertex_c,
    input  logic [47:0]                   world_vertex_a,
    input  logic [47:0]                   world_vertex_b,
    input  logic [47:0]                   world_vertex_c,
    output logic                          out_valid,
    output logic [uvw_pkg::RW-1:0]        n_out    [3],
    output logic [uvw_pkg::D_W-1:0]       d_out    [3],
    output uvw_pkg::side_t                side_out [3]
);

    localparam int UVD = uvw_pkg::UVD_W;
    localparam int PW  = uvw_pkg::PROD_W;
    localparam int CW  = uvw_pkg::CROSS_W;
    localparam int CRD = uvw_pkg::CRD_W;
    localparam int WD  = uvw_pkg::WD_W;
    localparam int WP  = uvw_pkg::WPROD_W;
    localparam int NW  = uvw_pkg::NUM_W;

    // Valid bits, one per stage.
    logic [5:0] v_reg;

    // Stage 1: UV and world differences.
    logic signed [UVD-1:0] du_reg, dv_reg, eu_reg, ev_reg, fu_reg, fv_reg;
    logic signed [WD-1:0]  wba1_reg [3];
    logic signed [WD-1:0]  wcb1_reg [3];
    logic signed [CRD-1:0] wa1_reg  [3];

    // Stage 2: partial cross products.
    logic signed [PW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [WD-1:0]  wba2_reg [3];
    logic signed [WD-1:0]  wcb2_reg [3];
    logic signed [CRD-1:0] wa2_reg  [3];

    // Stage 3: den, rn, sn.
    logic signed [CW-1:0]  den_reg, rn_reg, sn3_reg;
    logic signed [WD-1:0]  wba3_reg [3];
    logic signed [WD-1:0]  wcb3_reg [3];
    logic signed [CRD-1:0] wa3_reg  [3];

    // Stage 4: world products.
    logic signed [WP-1:0]  m1_reg [3];
    logic signed [WP-1:0]  m2_reg [3];
    logic signed [CW-1:0]  sn4_reg;
    logic                  degen4_reg;
    logic signed [CRD-1:0] wa4_reg [3];

    // Stage 5: numerators.
    logic signed [NW-1:0]  num_reg [3];
    logic signed [CW-1:0]  sn5_reg;
    logic                  degen5_reg;
    logic signed [CRD-1:0] wa5_reg [3];

    // Stage 6: divider operands.
    logic [uvw_pkg::RW-1:0]  n_reg    [3];
    logic [uvw_pkg::D_W-1:0] d_reg    [3];
    uvw_pkg::side_t          side_reg [3];

    // Unpacked UV components, zero extended to signed differences.
    logic signed [UVD-1:0] pu, pv, au, av, bu, bv, cu, cv;

    assign pu = $signed({1'b0, uv_point[15:0]});
    assign pv = $signed({1'b0, uv_point[31:16]});
    assign au = $signed({1'b0, uv_vertex_a[15:0]});
    assign av = $signed({1'b0, uv_vertex_a[31:16]});
    assign bu = $signed({1'b0, uv_vertex_b[15:0]});
    assign bv = $signed({1'b0, uv_vertex_b[31:16]});
    assign cu = $signed({1'b0, uv_vertex_c[15:0]});
    assign cv = $signed({1'b0, uv_vertex_c[31:16]});

    // Sign folding for stage 6.
    logic signed [CW:0] sn_ext;
    logic               sn_neg;
    logic [CW-1:0]      b_mag;
    logic signed [NW:0] num_adj [3];
    logic [NW-1:0]      a_mag   [3];
    logic               num_neg [3];

    always_comb
    begin
        sn_ext = {sn5_reg[CW-1], sn5_reg};
        sn_neg = sn5_reg[CW-1];
        b_mag  = sn_neg ? CW'(-sn_ext) : CW'(sn_ext);
        for (int k = 0; k < 3; k++)
        begin
            num_adj[k] = sn_neg ? -{num_reg[k][NW-1], num_reg[k]}
                                :  {num_reg[k][NW-1], num_reg[k]};
            num_neg[k] = num_adj[k][NW];
            a_mag[k]   = num_neg[k] ? NW'(-num_adj[k]) : NW'(num_adj[k]);
        end
    end

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // Data pipeline.
    always_ff @(posedge clk)
    begin
        // Stage 1.
        du_reg <= pu - au;
        dv_reg <= pv - av;
        eu_reg <= cu - bu;
        ev_reg <= cv - bv;
        fu_reg <= bu - au;
        fv_reg <= bv - av;
        for (int k = 0; k < 3; k++)
        begin
            wba1_reg[k] <= WD'($signed(world_vertex_b[16*k +: 16]))
                         - WD'($signed(world_vertex_a[16*k +: 16]));
            wcb1_reg[k] <= WD'($signed(world_vertex_c[16*k +: 16]))
                         - WD'($signed(world_vertex_b[16*k +: 16]));
            wa1_reg[k]  <= $signed(world_vertex_a[16*k +: 16]);
        end

        // Stage 2.
        p0_reg <= du_reg * ev_reg;
        p1_reg <= dv_reg * eu_reg;
        p2_reg <= fu_reg * dv_reg;
        p3_reg <= fv_reg * du_reg;
        p4_reg <= fu_reg * ev_reg;
        p5_reg <= fv_reg * eu_reg;
        wba2_reg <= wba1_reg;
        wcb2_reg <= wcb1_reg;
        wa2_reg  <= wa1_reg;

        // Stage 3.
        den_reg  <= CW'(p0_reg) - CW'(p1_reg);
        rn_reg   <= CW'(p2_reg) - CW'(p3_reg);
        sn3_reg  <= CW'(p4_reg) - CW'(p5_reg);
        wba3_reg <= wba2_reg;
        wcb3_reg <= wcb2_reg;
        wa3_reg  <= wa2_reg;

        // Stage 4.
        for (int k = 0; k < 3; k++)
        begin
            m1_reg[k] <= WP'(wba3_reg[k]) * WP'(den_reg);
            m2_reg[k] <= WP'(rn_reg) * WP'(wcb3_reg[k]);
        end
        sn4_reg    <= sn3_reg;
        degen4_reg <= (den_reg == '0) || (sn3_reg == '0);
        wa4_reg    <= wa3_reg;

        // Stage 5.
        for (int k = 0; k < 3; k++)
        begin
            num_reg[k] <= NW'(m1_reg[k]) + NW'(m2_reg[k]);
        end
        sn5_reg    <= sn4_reg;
        degen5_reg <= degen4_reg;
        wa5_reg    <= wa4_reg;

        // Stage 6.
        for (int k = 0; k < 3; k++)
        begin
            n_reg[k]          <= uvw_pkg::RW'({a_mag[k], 1'b0}) + uvw_pkg::RW'(b_mag);
            d_reg[k]          <= {b_mag, 1'b0};
            side_reg[k].neg   <= num_neg[k];
            side_reg[k].degen <= degen5_reg;
            side_reg[k].wa    <= wa5_reg[k];
        end
    end

    assign out_valid = v_reg[5];
    assign n_out     = n_reg;
    assign d_out     = d_reg;
    assign side_out  = side_reg;

endmodule

// ===== design/uvw_div.sv =====
// ============================================================================
// uvw_div
// Pipelined restoring divider, one quotient bit per stage, with overflow.
// ============================================================================
module uvw_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [uvw_pkg::RW-1:0]          n_in,
    input  logic [uvw_pkg::D_W-1:0]         d_in,
    input  uvw_pkg::side_t                  side_in,
    output logic                            out_valid,
    output logic [uvw_pkg::QUOT_BITS-1:0]   q_out,
    output logic                            ovf_out,
    output uvw_pkg::side_t                  side_out
);

    localparam int QB = uvw_pkg::QUOT_BITS;
    localparam int RW = uvw_pkg::RW;
    localparam int DW = uvw_pkg::D_W;

    // One register set per stage; stage 0 flags overflow and each later stage s decides quotient bit QB - s.
    logic                v_reg    [QB+1];
    logic [RW-1:0]       r_reg    [QB+1];
    logic [DW-1:0]       d_reg    [QB+1];
    logic [QB-1:0]       q_reg    [QB+1];
    logic                ovf_reg  [QB+1];
    uvw_pkg::side_t      side_reg [QB+1];

    for (genvar s = 0; s <= QB; s++)
    begin : g_stage
        localparam int P = QB - s;

        logic           v_prev;
        logic [RW-1:0]  r_prev;
        logic [DW-1:0]  d_prev;
        logic [QB-1:0]  q_prev;
        logic           ovf_prev;
        uvw_pkg::side_t side_prev;
        logic [RW-1:0]  shifted;
        logic           ge;

        if (s == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign r_prev    = n_in;
            assign d_prev    = d_in;
            assign q_prev    = '0;
            assign ovf_prev  = 1'b0;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[s-1];
            assign r_prev    = r_reg[s-1];
            assign d_prev    = d_reg[s-1];
            assign q_prev    = q_reg[s-1];
            assign ovf_prev  = ovf_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        // Trial compare against the shifted divisor.
        assign shifted = RW'(d_prev) << P;
        assign ge      = (r_prev >= shifted);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_prev;
            end
        end

        // The top stage only flags a quotient too large for the output range.
        always_ff @(posedge clk)
        begin
            d_reg[s]    <= d_prev;
            side_reg[s] <= side_prev;
            if (s == 0)
            begin
                r_reg[s]   <= r_prev;
                q_reg[s]   <= q_prev;
                ovf_reg[s] <= ge;
            end
            else
            begin
                r_reg[s]   <= ge ? (r_prev - shifted) : r_prev;
                q_reg[s]   <= q_prev | (QB'(ge) << (P % QB));
                ovf_reg[s] <= ovf_prev;
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign q_out     = q_reg[QB];
    assign ovf_out   = ovf_reg[QB];
    assign side_out  = side_reg[QB];

endmodule

// ===== design/uvw_back.sv =====
// ============================================================================
// uvw_back
// Applies the quotient sign, adds vertex A (alone when degenerate) and saturates.
// ============================================================================
module uvw_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [uvw_pkg::QUOT_BITS-1:0]        q_in    [3],
    input  logic                                 ovf_in  [3],
    input  uvw_pkg::side_t                       side_in [3],
    output logic                                 done,
    output logic signed [uvw_pkg::CRD_W-1:0]     world_x,
    output logic signed [uvw_pkg::CRD_W-1:0]     world_y,
    output logic signed [uvw_pkg::CRD_W-1:0]     world_z,
    output logic                                 degenerate
);

    localparam int QB  = uvw_pkg::QUOT_BITS;
    localparam int RSW = uvw_pkg::RES_W;
    localparam int CRD = uvw_pkg::CRD_W;
    localparam logic signed [RSW-1:0] SatHi = RSW'((1 << (CRD - 1)) - 1);
    localparam logic signed [RSW-1:0] SatLo = -SatHi - RSW'(1);

    logic                  done_reg;
    logic signed [CRD-1:0] res_reg [3];
    logic                  degen_reg;

    logic [QB:0]           q_mag  [3];
    logic signed [RSW-1:0] q_sgn  [3];
    logic signed [RSW-1:0] sum    [3];
    logic signed [CRD-1:0] res_next [3];

    // Quotients past the output range are clamped; the sum then saturates.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q_mag[k] = ovf_in[k] ? {1'b1, {QB{1'b0}}} : {1'b0, q_in[k]};
            q_sgn[k] = side_in[k].neg ? -$signed(RSW'(q_mag[k]))
                                      :  $signed(RSW'(q_mag[k]));
            sum[k]   = RSW'(side_in[k].wa)
                     + (side_in[k].degen ? RSW'(0) : q_sgn[k]);
            if (sum[k] > SatHi)
            begin
                res_next[k] = CRD'(SatHi);
            end
            else if (sum[k] < SatLo)
            begin
                res_next[k] = CRD'(SatLo);
            end
            else
            begin
                res_next[k] = CRD'(sum[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        degen_reg <= side_in[0].degen;
    end

    assign done       = done_reg;
    assign world_x    = res_reg[0];
    assign world_y    = res_reg[1];
    assign world_z    = res_reg[2];
    assign degenerate = degen_reg;

endmodule

// ===== design/uvw_checker.sv =====
// ============================================================================
// uvw_checker
// Port level checks on request and result timing and degenerate cases.
// ============================================================================
module uvw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] uv_point,
    input logic [31:0] uv_vertex_a,
    input logic [31:0] uv_vertex_b,
    input logic [31:0] uv_vertex_c,
    input logic [47:0] world_vertex_a,
    input logic        done,
    input logic [15:0] world_x,
    input logic        degenerate
);

    localparam int Lat = uvw_pkg::LATENCY;

    // Cycles since reset, saturating once the pipeline has filled.
    logic [5:0] age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else if (age_reg != 6'(Lat))
        begin
            age_reg <= age_reg + 6'd1;
        end
    end

    // The block takes a request in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Each result matches exactly one earlier request, once the pipeline has filled.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (age_reg == 6'(Lat)) |-> (done == $past(start, Lat)))
        else $error("result timing does not match request");

    // A point on vertex A gives vertex A, flagged degenerate.
    a_point_on_a: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && uv_point == uv_vertex_a) |-> ##Lat
        (done && degenerate && world_x == $past(world_vertex_a[15:0], Lat)))
        else $error("point on vertex A not reported as degenerate");

    // Coincident B and C leave no edge to cross.
    a_b_equals_c: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && uv_vertex_b == uv_vertex_c) |-> ##Lat
        (done && degenerate))
        else $error("coincident B and C not reported as degenerate");

endmodule

bind uv_to_world_position uvw_checker u_uvw_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .uv_point       (uv_point),
    .uv_vertex_a    (uv_vertex_a),
    .uv_vertex_b    (uv_vertex_b),
    .uv_vertex_c    (uv_vertex_c),
    .world_vertex_a (world_vertex_a),
    .done           (done),
    .world_x        (world_x),
    .degenerate     (degenerate)
);
